/* src/keyed_mailbox_queue_engine_assert.svh */
// Assertion macros for the keyed mailbox queue engine.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef KEYED_MAILBOX_QUEUE_ENGINE_ASSERT_SVH
`define KEYED_MAILBOX_QUEUE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define KMQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
`define KMQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define KMQ_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define KMQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/kmq_pkg.sv */
// Shared types and codes for the keyed mailbox queue engine.
// No dependencies; used by all modules through scoped names.
package kmq_pkg;

	localparam logic [1:0] CMD_CREATE = 2'd0;
	localparam logic [1:0] CMD_SEND   = 2'd1;
	localparam logic [1:0] CMD_RECV   = 2'd2;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_BAD    = 3'd1;
	localparam logic [2:0] ST_NOSLOT = 3'd2;
	localparam logic [2:0] ST_FULL   = 3'd3;
	localparam logic [2:0] ST_EMPTY  = 3'd4;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic set_active;
	} box_ctl_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} msg_ctl_t;

endpackage

/* src/kmq_box_table.sv */
// Mailbox table: per-box key, ring pointers and fill count in one RAM,
// plus the active marks in flip-flops. Depends on kmq_pkg.
module kmq_box_table #(
	parameter int NUM_BOXES = 64,
	parameter int EW = 45,
	localparam int AW = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kmq_pkg::box_ctl_t     ctl,
	input  logic [AW-1:0]         rd_addr,
	input  logic [AW-1:0]         wr_addr,
	input  logic [EW-1:0]         wr_data,
	output logic [EW-1:0]         rd_data,
	output logic [NUM_BOXES-1:0]  active
);
	logic [EW-1:0] mem [NUM_BOXES];
	logic [EW-1:0] rdata_q;
	logic [NUM_BOXES-1:0] active_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (ctl.set_active) begin
			active_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rdata_q;
	assign active  = active_q;

endmodule

/* src/kmq_msg_store.sv */
// Message RAM: one ring of BOX_DEPTH words per mailbox, addressed by box and slot.
// Depends on kmq_pkg.
module kmq_msg_store #(
	parameter int NUM_BOXES = 64,
	parameter int BOX_DEPTH = 16,
	localparam int BW = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1,
	localparam int PW = $clog2(BOX_DEPTH)
) (
	input  logic               clk,
	input  kmq_pkg::msg_ctl_t  ctl,
	input  logic [BW-1:0]      box,
	input  logic [PW-1:0]      wr_ptr,
	input  logic [PW-1:0]      rd_ptr,
	input  logic [31:0]        wr_data,
	output logic [31:0]        rd_data
);
	localparam int MAW = $clog2(NUM_BOXES * BOX_DEPTH);

	logic [31:0]    mem [NUM_BOXES * BOX_DEPTH];
	logic [31:0]    rdata_q;
	logic [MAW-1:0] base;
	logic [MAW-1:0] wr_addr;
	logic [MAW-1:0] rd_addr;

	assign base    = MAW'(MAW'(box) * MAW'(BOX_DEPTH));
	assign wr_addr = MAW'(base + MAW'(wr_ptr));
	assign rd_addr = MAW'(base + MAW'(rd_ptr));

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	assign rd_data = rdata_q;

endmodule

/* src/keyed_mailbox_queue_engine.sv */
// Top level of the keyed mailbox queue engine: command sequencer and result register.
// Depends on kmq_pkg, kmq_box_table, kmq_msg_store and the assertion header.
//
// channel  dir  signals                         content (low bit up)
// s        in   s_tvalid s_tready s_tdata s_tuser  tuser: cmd; tdata: key, index, message
// m        out  m_tvalid m_tready m_tdata          tdata: status, index, found, message
//
// A rejected command goes straight to the result; send takes one table RAM read,
// receive a table RAM read and then a message RAM read, and create a serial key
// scan through the table RAM, one entry per cycle.
// One command at a time; the next input transfer is taken once the result is in
// the output register, even while that result waits for m_tready.
// Reset clears the active marks at once; no clearing pass.
`include "keyed_mailbox_queue_engine_assert.svh"
module keyed_mailbox_queue_engine #(
	parameter int NUM_BOXES = 64,
	parameter int BOX_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // mailbox_key[31:0], box_index[39:32], message_in[71:40]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // result_status[2:0], result_index[8:3],
	                               // found_existing[9], message_out[41:10]
);
	localparam int BW = (NUM_BOXES > 1) ? $clog2(NUM_BOXES) : 1;
	localparam int PW = $clog2(BOX_DEPTH);
	localparam int CW = $clog2(BOX_DEPTH + 1);
	localparam int EW = 32 + 2 * PW + CW;
	localparam int WP_LSB  = CW;
	localparam int RP_LSB  = CW + PW;
	localparam int KEY_LSB = CW + 2 * PW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_CTRL = 3'd2;
	localparam logic [2:0] S_MSG  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]    state_q;
	logic [1:0]    cmd_q;
	logic [31:0]   key_q;
	logic [BW-1:0] idx_q;
	logic [31:0]   msg_q;
	logic [BW-1:0] chk_q;
	logic [BW-1:0] free_q;
	logic          free_found_q;
	logic [2:0]    res_status_q;
	logic [5:0]    res_index_q;
	logic          res_found_q;
	logic [31:0]   res_msg_q;
	logic          m_valid_q;
	logic [47:0]   m_data_q;

	kmq_pkg::box_ctl_t    box_ctl;
	kmq_pkg::msg_ctl_t    msg_ctl;
	logic [BW-1:0]        box_rd_addr;
	logic [BW-1:0]        box_wr_addr;
	logic [EW-1:0]        box_wr_data;
	logic [EW-1:0]        box_rdata;
	logic [NUM_BOXES-1:0] box_active;
	logic [31:0]          msg_rdata;

	logic          accept;
	logic [1:0]    in_cmd;
	logic [BW-1:0] in_idx;
	logic          in_idx_ok;
	logic          in_is_box_cmd;
	logic          load_out;

	logic [31:0]   ent_key;
	logic [PW-1:0] ent_rp;
	logic [PW-1:0] ent_wp;
	logic [CW-1:0] ent_cnt;
	logic [PW-1:0] rp_nx;
	logic [PW-1:0] wp_nx;
	logic          box_full;
	logic          box_empty;

	logic          scan_act;
	logic          scan_hit;
	logic          scan_last;
	logic          scan_free_now;
	logic          scan_claim;
	logic [BW-1:0] free_idx_c;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_cmd   = s_tuser;
	assign in_idx   = s_tdata[32 +: BW];
	assign in_idx_ok = ({1'b0, s_tdata[39:32]} < 9'(NUM_BOXES)) && box_active[in_idx];
	assign in_is_box_cmd = (in_cmd == kmq_pkg::CMD_SEND) || (in_cmd == kmq_pkg::CMD_RECV);
	assign load_out = (state_q == S_DONE) && (!m_valid_q || m_tready);

	assign ent_key = box_rdata[KEY_LSB +: 32];
	assign ent_rp  = box_rdata[RP_LSB +: PW];
	assign ent_wp  = box_rdata[WP_LSB +: PW];
	assign ent_cnt = box_rdata[CW-1:0];
	assign rp_nx   = (ent_rp == PW'(BOX_DEPTH - 1)) ? '0 : PW'(ent_rp + 1'b1);
	assign wp_nx   = (ent_wp == PW'(BOX_DEPTH - 1)) ? '0 : PW'(ent_wp + 1'b1);
	assign box_full  = (ent_cnt == CW'(BOX_DEPTH));
	assign box_empty = (ent_cnt == '0);

	assign scan_act      = box_active[chk_q];
	assign scan_hit      = scan_act && (ent_key == key_q);
	assign scan_last     = (chk_q == BW'(NUM_BOXES - 1));
	assign scan_free_now = !free_found_q && !scan_act;
	assign scan_claim    = free_found_q || !scan_act;
	assign free_idx_c    = free_found_q ? free_q : chk_q;

	always_comb begin
		box_ctl     = '0;
		msg_ctl     = '0;
		box_rd_addr = '0;
		box_wr_addr = idx_q;
		box_wr_data = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_cmd == kmq_pkg::CMD_CREATE) begin
						box_ctl.rd_en = 1'b1;
					end else if (in_is_box_cmd && in_idx_ok) begin
						box_ctl.rd_en = 1'b1;
						box_rd_addr   = in_idx;
					end
				end
			end
			S_SCAN: begin
				if (!scan_hit) begin
					if (scan_last) begin
						if (scan_claim) begin
							box_ctl.wr_en      = 1'b1;
							box_ctl.set_active = 1'b1;
							box_wr_addr        = free_idx_c;
							box_wr_data        = {key_q, {(EW - 32){1'b0}}};
						end
					end else begin
						box_ctl.rd_en = 1'b1;
						box_rd_addr   = BW'(chk_q + 1'b1);
					end
				end
			end
			S_CTRL: begin
				if (cmd_q == kmq_pkg::CMD_SEND && !box_full) begin
					box_ctl.wr_en = 1'b1;
					msg_ctl.wr_en = 1'b1;
					box_wr_data   = {ent_key, ent_rp, wp_nx, CW'(ent_cnt + 1'b1)};
				end else if (cmd_q == kmq_pkg::CMD_RECV && !box_empty) begin
					box_ctl.wr_en = 1'b1;
					msg_ctl.rd_en = 1'b1;
					box_wr_data   = {ent_key, rp_nx, ent_wp, CW'(ent_cnt - 1'b1)};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			m_valid_q    <= 1'b0;
			chk_q        <= '0;
			free_found_q <= 1'b0;
		end else begin
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						chk_q        <= '0;
						free_found_q <= 1'b0;
						if (in_cmd == kmq_pkg::CMD_CREATE) begin
							state_q <= S_SCAN;
						end else if (in_is_box_cmd && in_idx_ok) begin
							state_q <= S_CTRL;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (scan_hit || scan_last) begin
						state_q <= S_DONE;
					end else begin
						chk_q <= BW'(chk_q + 1'b1);
						if (scan_free_now) begin
							free_found_q <= 1'b1;
						end
					end
				end
				S_CTRL: begin
					if (cmd_q == kmq_pkg::CMD_RECV && !box_empty) begin
						state_q <= S_MSG;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_MSG: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q        <= in_cmd;
					key_q        <= s_tdata[31:0];
					idx_q        <= in_idx;
					msg_q        <= s_tdata[71:40];
					res_status_q <= kmq_pkg::ST_BAD;
					res_index_q  <= '0;
					res_found_q  <= 1'b0;
					res_msg_q    <= '0;
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					res_status_q <= kmq_pkg::ST_OK;
					res_index_q  <= 6'(chk_q);
					res_found_q  <= 1'b1;
				end else if (scan_last) begin
					if (scan_claim) begin
						res_status_q <= kmq_pkg::ST_OK;
						res_index_q  <= 6'(free_idx_c);
					end else begin
						res_status_q <= kmq_pkg::ST_NOSLOT;
					end
				end else if (scan_free_now) begin
					free_q <= chk_q;
				end
			end
			S_CTRL: begin
				if (cmd_q == kmq_pkg::CMD_SEND) begin
					res_status_q <= box_full ? kmq_pkg::ST_FULL : kmq_pkg::ST_OK;
				end else begin
					res_status_q <= box_empty ? kmq_pkg::ST_EMPTY : kmq_pkg::ST_OK;
				end
			end
			S_MSG: begin
				res_msg_q <= msg_rdata;
			end
			S_DONE: begin
				if (load_out) begin
					m_data_q <= {6'b0, res_msg_q, res_found_q, res_index_q, res_status_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	kmq_box_table #(
		.NUM_BOXES (NUM_BOXES),
		.EW        (EW)
	) u_box_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (box_ctl),
		.rd_addr (box_rd_addr),
		.wr_addr (box_wr_addr),
		.wr_data (box_wr_data),
		.rd_data (box_rdata),
		.active  (box_active)
	);

	kmq_msg_store #(
		.NUM_BOXES (NUM_BOXES),
		.BOX_DEPTH (BOX_DEPTH)
	) u_msg_store (
		.clk     (clk),
		.ctl     (msg_ctl),
		.box     (idx_q),
		.wr_ptr  (ent_wp),
		.rd_ptr  (ent_rp),
		.wr_data (msg_q),
		.rd_data (msg_rdata)
	);

	`KMQ_ASSERT_IMP(a_scan_in_range, clk, arst_n, state_q == S_SCAN, {1'b0, chk_q} < (BW + 1)'(NUM_BOXES), "scan index beyond table")
	`KMQ_ASSERT_IMP(a_msg_write_on_send, clk, arst_n, msg_ctl.wr_en, state_q == S_CTRL && cmd_q == kmq_pkg::CMD_SEND, "message write outside send")
	`KMQ_ASSERT_IMP(a_claim_free_slot, clk, arst_n, box_ctl.set_active, !box_active[box_wr_addr], "claim of an active mailbox")
	`KMQ_ASSERT_IMP(a_msg_after_ctrl, clk, arst_n, state_q == S_MSG, $past(state_q) == S_CTRL, "message read without table read")
	`KMQ_ASSERT_NEXT(a_done_loads_out, clk, arst_n, load_out, m_tvalid && state_q == S_IDLE, "result not moved to output")

endmodule

/* tb/tb_keyed_mailbox_queue_engine.sv */
// Self-checking testbench for keyed_mailbox_queue_engine: create, send, receive and invalid-command traffic.
// Depends on kmq_pkg and the engine RTL; predicts every reply with its own mailbox table.
`timescale 1ns / 100ps
module tb_keyed_mailbox_queue_engine;

	localparam int MBOX_COUNT = 64;
	localparam int MBOX_DEPTH = 16;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int RANDOM_ITEMS = 1700;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  cmd;
		logic [31:0] key;
		logic [7:0]  idx;
		logic [31:0] msg;
		bit          drain;
	} mbox_cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  index;
		logic        found;
		logic [31:0] message;
	} mbox_reply_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;

	mbox_cmd_t   cmd_backlog[$];
	mbox_cmd_t   cmd_on_bus;
	mbox_reply_t expected_replies[$];
	mbox_reply_t want_reply;
	logic [31:0] issued_keys[$];
	int          queued_count = 0;
	int          sent_count = 0;
	int          fail_count = 0;
	int          cycle_count = 0;

	bit          box_live[MBOX_COUNT];
	logic [31:0] box_key[MBOX_COUNT];
	logic [31:0] box_ring[MBOX_COUNT][MBOX_DEPTH];
	int          box_head[MBOX_COUNT];
	int          box_tail[MBOX_COUNT];
	int          box_fill[MBOX_COUNT];

	keyed_mailbox_queue_engine #(
		.NUM_BOXES(MBOX_COUNT),
		.BOX_DEPTH(MBOX_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic mbox_reply_t mailbox_predict(input mbox_cmd_t c);
		mbox_reply_t r;
		int hit;
		int slot;
		r = '0;
		r.status = kmq_pkg::ST_BAD;
		hit = -1;
		slot = -1;
		if (c.cmd == kmq_pkg::CMD_CREATE) begin
			for (int i = 0; i < MBOX_COUNT; i++)
				if (hit < 0 && box_live[i] && box_key[i] == c.key)
					hit = i;
			if (hit >= 0) begin
				r.status = kmq_pkg::ST_OK;
				r.index = hit[5:0];
				r.found = 1'b1;
			end else begin
				for (int i = 0; i < MBOX_COUNT; i++)
					if (slot < 0 && !box_live[i])
						slot = i;
				if (slot >= 0) begin
					box_live[slot] = 1'b1;
					box_key[slot] = c.key;
					box_head[slot] = 0;
					box_tail[slot] = 0;
					box_fill[slot] = 0;
					r.status = kmq_pkg::ST_OK;
					r.index = slot[5:0];
				end else begin
					r.status = kmq_pkg::ST_NOSLOT;
				end
			end
		end else if ((c.cmd == kmq_pkg::CMD_SEND || c.cmd == kmq_pkg::CMD_RECV)
				&& c.idx < MBOX_COUNT && box_live[c.idx]) begin
			if (c.cmd == kmq_pkg::CMD_SEND) begin
				if (box_fill[c.idx] >= MBOX_DEPTH) begin
					r.status = kmq_pkg::ST_FULL;
				end else begin
					box_ring[c.idx][box_tail[c.idx]] = c.msg;
					box_tail[c.idx] = (box_tail[c.idx] + 1) % MBOX_DEPTH;
					box_fill[c.idx]++;
					r.status = kmq_pkg::ST_OK;
				end
			end else begin
				if (box_fill[c.idx] == 0) begin
					r.status = kmq_pkg::ST_EMPTY;
				end else begin
					r.message = box_ring[c.idx][box_head[c.idx]];
					box_head[c.idx] = (box_head[c.idx] + 1) % MBOX_DEPTH;
					box_fill[c.idx]--;
					r.status = kmq_pkg::ST_OK;
				end
			end
		end
		return r;
	endfunction

	task automatic queue_cmd(input logic [1:0] cmd, input logic [31:0] key,
			input logic [7:0] idx, input logic [31:0] msg);
		mbox_cmd_t c;
		bit known;
		c.cmd = cmd;
		c.key = key;
		c.idx = idx;
		c.msg = msg;
		c.drain = (queued_count == 320 || queued_count == 1020);
		known = 1'b0;
		if (cmd == kmq_pkg::CMD_CREATE) begin
			foreach (issued_keys[i])
				if (issued_keys[i] == key)
					known = 1'b1;
			if (!known)
				issued_keys.push_back(key);
		end
		cmd_backlog.push_back(c);
		queued_count++;
	endtask

	function automatic int live_boxes();
		return (issued_keys.size() < MBOX_COUNT) ? issued_keys.size() : MBOX_COUNT;
	endfunction

	task automatic queue_random_traffic();
		int pick;
		int n;
		int box;
		int burst;
		logic [31:0] k;
		pick = $urandom_range(99);
		n = live_boxes();
		if (pick < 40 || n == 0) begin
			burst = $urandom_range(1, 4);
			repeat (burst) begin
				if ($urandom_range(99) < 70 || issued_keys.size() == 0)
					k = $urandom;
				else
					k = issued_keys[$urandom_range(issued_keys.size() - 1)];
				queue_cmd(kmq_pkg::CMD_CREATE, k, 8'($urandom), $urandom);
			end
		end else if (pick < 50) begin
			case ($urandom_range(2))
				0: queue_cmd(CMD_UNUSED, $urandom, 8'($urandom), $urandom);
				1: queue_cmd(2'($urandom_range(1, 2)), $urandom, 8'($urandom_range(64, 255)),
					$urandom);
				default: begin
					box = (n < MBOX_COUNT) ? $urandom_range(n, MBOX_COUNT - 1)
						: $urandom_range(MBOX_COUNT, 255);
					queue_cmd(2'($urandom_range(1, 2)), $urandom, 8'(box), $urandom);
				end
			endcase
		end else begin
			box = $urandom_range(n - 1);
			burst = $urandom_range(1, 20);
			repeat (burst)
				queue_cmd(kmq_pkg::CMD_SEND, $urandom, 8'(box), $urandom);
			burst = $urandom_range(1, 20);
			repeat (burst)
				queue_cmd(kmq_pkg::CMD_RECV, $urandom, 8'(box), $urandom);
		end
	endtask

	initial begin
		queue_cmd(kmq_pkg::CMD_SEND, 32'h0, 8'd0, 32'h1234_5678);
		queue_cmd(kmq_pkg::CMD_RECV, 32'h0, 8'd63, 32'h0);
		queue_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
		queue_cmd(kmq_pkg::CMD_CREATE, 32'h8000_0000, 8'h0, 32'h0);
		queue_cmd(kmq_pkg::CMD_CREATE, 32'h7FFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
		queue_cmd(kmq_pkg::CMD_CREATE, 32'h8000_0000, 8'h0, 32'h0);
		queue_cmd(kmq_pkg::CMD_CREATE, 32'h0000_0000, 8'h0, 32'h0);
		queue_cmd(kmq_pkg::CMD_CREATE, 32'hFFFF_FFFF, 8'h0, 32'h0);
		queue_cmd(kmq_pkg::CMD_RECV, 32'h0, 8'd0, 32'h0);
		queue_cmd(kmq_pkg::CMD_SEND, 32'h0, 8'd0, 32'h8000_0000);
		queue_cmd(kmq_pkg::CMD_SEND, 32'hFFFF_FFFF, 8'd0, 32'h7FFF_FFFF);
		queue_cmd(kmq_pkg::CMD_SEND, 32'h0, 8'd1, 32'hFFFF_FFFF);
		queue_cmd(kmq_pkg::CMD_SEND, 32'h0, 8'd1, 32'h0000_0000);
		queue_cmd(kmq_pkg::CMD_SEND, 32'h0, 8'd64, 32'h5555_5555);
		queue_cmd(kmq_pkg::CMD_RECV, 32'h0, 8'd255, 32'h0);
		queue_cmd(kmq_pkg::CMD_SEND, 32'h0, 8'd128, 32'hAAAA_AAAA);
		queue_cmd(kmq_pkg::CMD_RECV, 32'h0, 8'd0, 32'h0);
		queue_cmd(kmq_pkg::CMD_RECV, 32'h0, 8'd0, 32'h0);
		queue_cmd(kmq_pkg::CMD_RECV, 32'h0, 8'd0, 32'h0);
		queue_cmd(kmq_pkg::CMD_RECV, 32'h0, 8'd1, 32'h0);
		queue_cmd(kmq_pkg::CMD_RECV, 32'h0, 8'd1, 32'h0);
		queue_cmd(kmq_pkg::CMD_CREATE, 32'hFFFF_FFFF, 8'h0, 32'h0);
		while (queued_count < RANDOM_ITEMS + 22)
			queue_random_traffic();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_backlog.size() != 0 || s_tvalid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (MBOX_COUNT + 10) @(posedge clk);
		if (fail_count == 0)
			$display("tb_keyed_mailbox_queue_engine OK");
		else
			$display("tb_keyed_mailbox_queue_engine NOT OK");
		$finish;
	end

	// idle percentages per phase of the run
	function automatic int sender_idle_pct();
		return (sent_count < 600) ? 12 : (sent_count < 1200) ? 52 : 0;
	endfunction

	function automatic int receiver_stall_pct();
		return (sent_count < 600) ? 52 : (sent_count < 1200) ? 12 : 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				expected_replies.push_back(mailbox_predict(cmd_on_bus));
				sent_count++;
			end
			if (cmd_backlog.size() != 0
					&& !(cmd_backlog[0].drain && expected_replies.size() != 0)
					&& $urandom_range(99) >= sender_idle_pct()) begin
				cmd_on_bus = cmd_backlog.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {cmd_on_bus.msg, cmd_on_bus.idx, cmd_on_bus.key};
				s_tuser <= cmd_on_bus.cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					$error("result transfer with no command outstanding: %h", m_tdata);
					fail_count++;
				end else begin
					want_reply = expected_replies.pop_front();
					if (m_tdata[2:0] !== want_reply.status) begin
						$error("result_status: expected %0d, actual %0d",
							want_reply.status, m_tdata[2:0]);
						fail_count++;
					end
					if (m_tdata[8:3] !== want_reply.index) begin
						$error("result_index: expected %0d, actual %0d",
							want_reply.index, m_tdata[8:3]);
						fail_count++;
					end
					if (m_tdata[9] !== want_reply.found) begin
						$error("found_existing: expected %0d, actual %0d",
							want_reply.found, m_tdata[9]);
						fail_count++;
					end
					if (m_tdata[41:10] !== want_reply.message) begin
						$error("message_out: expected %h, actual %h",
							want_reply.message, m_tdata[41:10]);
						fail_count++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= receiver_stall_pct());
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_keyed_mailbox_queue_engine NOT OK");
			$finish;
		end
	end

endmodule

/* files.f */
+incdir+src
src/kmq_pkg.sv
src/kmq_box_table.sv
src/kmq_msg_store.sv
src/keyed_mailbox_queue_engine.sv
tb/tb_keyed_mailbox_queue_engine.sv
